>>> hdl/hpsc_pkg.sv
// Shared types, codes and helpers of the power state coordinator.
package hpsc_pkg;

    localparam int CPC_DEFAULT      = 4;
    localparam int CLUSTERS_DEFAULT = 2;
    localparam int CMDQ_DEPTH       = 2;
    localparam int RESQ_DEPTH       = 2;

    localparam logic [1:0] PS_ON  = 2'd0;
    localparam logic [1:0] PS_OFF = 2'd3;

    localparam logic [1:0] REG_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_CORES0   = 2'd1;
    localparam logic [1:0] REG_CORES1   = 2'd2;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_POLL   = 2'd2,
        KIND_RESUME = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ACT_REPLY        = 4'd0,
        ACT_SUSP_CORE    = 4'd1,
        ACT_SUSP_CLUSTER = 4'd2,
        ACT_SUSP_COMPLEX = 4'd3,
        ACT_SYS_SUSPEND  = 4'd4,
        ACT_RES_COMPLEX  = 4'd5,
        ACT_RES_CLUSTER  = 4'd6,
        ACT_RES_CORE     = 4'd7,
        ACT_POLL_DONE    = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_GET    = 3'd1,
        OP_POLL   = 3'd2,
        OP_RESUME = 3'd3,
        OP_ERR    = 3'd4
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  cluster_sel;
        logic [2:0]  core_sel;
        logic [1:0]  req_core_state;
        logic [1:0]  req_cluster_state;
        logic [1:0]  req_complex_state;
        logic [15:0] irq_status;
    } t_req;

    typedef struct packed {
        logic [3:0] action;
        logic       act_cluster;
        logic [1:0] act_core;
        logic [1:0] act_state;
        logic       status;
        logic [1:0] cluster_state_out;
        logic [3:0] online_mask;
        logic       last;
    } t_res;

    // counts already saturated to the build limits
    typedef struct packed {
        logic [1:0] cl_cnt;
        logic [2:0] co_cnt0;
        logic [2:0] co_cnt1;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic        cluster;
        logic [2:0]  core;
        logic [1:0]  cst;
        logic [1:0]  clst;
        logic [1:0]  cxst;
        logic [15:0] irq;
    } t_cmd;

    function automatic logic [2:0] core_cnt(t_cfg c, logic cl);
        return cl ? c.co_cnt1 : c.co_cnt0;
    endfunction

endpackage

>>> hdl/hpsc_fifo.sv
// Small register FIFO used for the command and result queues.
module hpsc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/hpsc_front.sv
// Request intake: checks selectors and queues decoded commands.
module hpsc_front
    import hpsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output t_cmd o_cmd,
    output logic o_cmd_empty,
    input  logic i_cmd_pop
);
    t_cmd cmd;
    logic cl_bad, co_bad;

    always_comb begin
        cl_bad = {1'b0, i_req.cluster_sel} >= {1'b0, i_cfg.cl_cnt};
        co_bad = i_req.core_sel >= core_cnt(i_cfg, i_req.cluster_sel[0]);
        cmd.cluster = i_req.cluster_sel[0];
        cmd.core    = i_req.core_sel;
        cmd.cst     = i_req.req_core_state;
        cmd.clst    = i_req.req_cluster_state;
        cmd.cxst    = i_req.req_complex_state;
        cmd.irq     = i_req.irq_status;
        case (i_req.kind)
            KIND_SET:    cmd.op = (cl_bad || co_bad) ? OP_ERR : OP_SET;
            KIND_GET:    cmd.op = cl_bad ? OP_ERR : OP_GET;
            KIND_POLL:   cmd.op = OP_POLL;
            KIND_RESUME: cmd.op = OP_RESUME;
            default:     cmd.op = OP_ERR;
        endcase
    end

    hpsc_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

>>> hdl/hpsc_back.sv
// Command sequencer: holds the power states and emits the action stream.
module hpsc_back
    import hpsc_pkg::*;
#(
    parameter int CORES_PER_CLUSTER = CPC_DEFAULT,
    parameter int CLUSTER_COUNT     = CLUSTERS_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic empty,
    input  logic pop
);
    localparam int NCORE = CLUSTER_COUNT * CORES_PER_CLUSTER;
    localparam int IW    = NCORE > 1 ? $clog2(NCORE) : 1;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_SUSP_CORE = 12'b000000000010,
        S_SUSP_CL   = 12'b000000000100,
        S_SUSP_CX   = 12'b000000001000,
        S_SYS       = 12'b000000010000,
        S_RES_CX    = 12'b000000100000,
        S_RES_CL    = 12'b000001000000,
        S_RES_CO    = 12'b000010000000,
        S_SCAN      = 12'b000100000000,
        S_POLL_DONE = 12'b001000000000,
        S_GET       = 12'b010000000000,
        S_REPLY     = 12'b100000000000
    } t_state;

    function automatic logic [IW-1:0] cidx(logic cl, logic [2:0] co);
        return IW'(int'(cl) * CORES_PER_CLUSTER + int'(co));
    endfunction

    t_state     r_state, n_state;
    t_cmd       r_cmd;
    logic       r_tcl;
    logic [2:0] r_tco;
    logic       r_err;
    logic [1:0] r_core_st [NCORE];
    logic [1:0] r_cl_st [CLUSTER_COUNT];
    logic [1:0] r_cx_st;
    logic       r_lead_cl;
    logic [1:0] r_lead_co;

    t_res       res;
    logic       res_push, res_full, go;
    logic [1:0] cl_min, cx_min, cur_core;
    logic [3:0] mask;
    logic       hit, lead_ok, scan_last;
    logic [2:0] scan_co;
    logic       scan_cl;

    assign go        = !res_full;
    assign cur_core  = r_core_st[cidx(r_tcl, r_tco)];
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign lead_ok   = ({1'b0, r_lead_cl} < i_cfg.cl_cnt)
                    && ({1'b0, r_lead_co} < core_cnt(i_cfg, r_lead_cl));

    // minima over children, online mask and interrupt hit for the target core
    always_comb begin
        int k, kf;
        cl_min = r_cmd.clst;
        for (int j = 0; j < CORES_PER_CLUSTER; j++) begin
            if (j < int'(core_cnt(i_cfg, r_tcl))
                && r_core_st[cidx(r_tcl, 3'(j))] < cl_min) begin
                cl_min = r_core_st[cidx(r_tcl, 3'(j))];
            end
        end
        cx_min = r_cmd.cxst;
        for (int i = 0; i < CLUSTER_COUNT; i++) begin
            if (i < int'(i_cfg.cl_cnt) && r_cl_st[i] < cx_min) begin
                cx_min = r_cl_st[i];
            end
        end
        mask = '0;
        for (int j = 0; j < 4; j++) begin
            if (j < CORES_PER_CLUSTER) begin
                mask[j] = r_core_st[cidx(r_tcl, 3'(j))] != PS_OFF;
            end
        end
        k   = int'(r_tcl) * CORES_PER_CLUSTER + int'(r_tco);
        kf  = k + 2 * CORES_PER_CLUSTER;
        hit = (k < 16 && r_cmd.irq[4'(k)]) || (kf < 16 && r_cmd.irq[4'(kf)]);
    end

    // next core of the poll walk
    always_comb begin
        scan_last = 1'b0;
        scan_cl   = r_tcl;
        scan_co   = r_tco + 1'b1;
        if (r_tco == 3'(CORES_PER_CLUSTER - 1)) begin
            scan_co = '0;
            scan_cl = 1'b1;
            if (!(r_tcl == 1'b0 && i_cfg.cl_cnt > 2'd1)) begin
                scan_last = 1'b1;
            end
        end
    end

    always_comb begin
        res          = '0;
        res_push     = 1'b0;
        res.act_cluster = r_tcl;
        res.act_core    = r_tco[1:0];
        case (r_state)
            S_SUSP_CORE: begin
                res_push      = 1'b1;
                res.action    = ACT_SUSP_CORE;
                res.act_state = r_cmd.cst;
            end
            S_SUSP_CL: begin
                res_push      = 1'b1;
                res.action    = ACT_SUSP_CLUSTER;
                res.act_state = cl_min;
            end
            S_SUSP_CX: begin
                res_push      = 1'b1;
                res.action    = ACT_SUSP_COMPLEX;
                res.act_state = cx_min;
            end
            S_SYS: begin
                res_push      = 1'b1;
                res.action    = ACT_SYS_SUSPEND;
                res.act_state = PS_OFF;
            end
            S_RES_CX: begin
                res_push      = 1'b1;
                res.action    = ACT_RES_COMPLEX;
                res.act_state = r_cx_st;
            end
            S_RES_CL: begin
                res_push      = 1'b1;
                res.action    = ACT_RES_CLUSTER;
                res.act_state = r_cl_st[r_tcl];
            end
            S_RES_CO: begin
                res_push      = 1'b1;
                res.action    = ACT_RES_CORE;
                res.act_state = cur_core;
                res.last      = r_cmd.op == OP_RESUME;
            end
            S_POLL_DONE: begin
                res_push    = 1'b1;
                res         = '0;
                res.action  = ACT_POLL_DONE;
                res.last    = 1'b1;
            end
            S_GET: begin
                res_push              = 1'b1;
                res                   = '0;
                res.action            = ACT_REPLY;
                res.cluster_state_out = r_cl_st[r_tcl];
                res.online_mask       = mask;
                res.last              = 1'b1;
            end
            S_REPLY: begin
                res_push   = 1'b1;
                res        = '0;
                res.action = ACT_REPLY;
                res.status = r_err;
                res.last   = 1'b1;
            end
            default: begin
                res_push = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        OP_SET:    n_state = (i_cmd.cst != PS_ON) ? S_SUSP_CORE : S_RES_CX;
                        OP_GET:    n_state = S_GET;
                        OP_POLL:   n_state = (i_cfg.cl_cnt == '0) ? S_POLL_DONE : S_SCAN;
                        OP_RESUME: n_state = lead_ok ? S_RES_CX : S_REPLY;
                        default:   n_state = S_REPLY;
                    endcase
                end
            end
            S_SUSP_CORE: if (go) n_state = S_SUSP_CL;
            S_SUSP_CL:   if (go) n_state = S_SUSP_CX;
            S_SUSP_CX:   if (go) n_state = (cx_min == PS_OFF) ? S_SYS : S_REPLY;
            S_SYS:       if (go) n_state = S_REPLY;
            S_RES_CX:    if (go) n_state = S_RES_CL;
            S_RES_CL:    if (go) n_state = S_RES_CO;
            S_RES_CO: begin
                if (go) begin
                    case (r_cmd.op)
                        OP_SET:  n_state = S_REPLY;
                        OP_POLL: n_state = scan_last ? S_POLL_DONE : S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit && cur_core == PS_OFF && r_tco < core_cnt(i_cfg, r_tcl)) begin
                    n_state = S_RES_CX;
                end else if (scan_last) begin
                    n_state = S_POLL_DONE;
                end
            end
            S_POLL_DONE, S_GET, S_REPLY: if (go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cx_st   <= PS_ON;
            r_lead_cl <= 1'b0;
            r_lead_co <= '0;
            for (int i = 0; i < NCORE; i++) begin
                r_core_st[i] <= (i == 0) ? PS_ON : PS_OFF;
            end
            for (int i = 0; i < CLUSTER_COUNT; i++) begin
                r_cl_st[i] <= (i == 0) ? PS_ON : PS_OFF;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_err <= i_cmd.op != OP_SET;
                        case (i_cmd.op)
                            OP_POLL: begin
                                r_tcl <= 1'b0;
                                r_tco <= '0;
                            end
                            OP_RESUME: begin
                                r_tcl <= r_lead_cl;
                                r_tco <= {1'b0, r_lead_co};
                            end
                            default: begin
                                r_tcl <= i_cmd.cluster;
                                r_tco <= i_cmd.core;
                            end
                        endcase
                    end
                end
                S_SUSP_CORE: if (go) r_core_st[cidx(r_tcl, r_tco)] <= r_cmd.cst;
                S_SUSP_CL:   if (go) r_cl_st[r_tcl] <= cl_min;
                S_SUSP_CX:   if (go) r_cx_st <= cx_min;
                S_SYS: begin
                    if (go) begin
                        r_lead_cl <= r_tcl;
                        r_lead_co <= r_tco[1:0];
                    end
                end
                S_RES_CX: if (go) r_cx_st <= PS_ON;
                S_RES_CL: if (go) r_cl_st[r_tcl] <= PS_ON;
                S_RES_CO: begin
                    if (go) begin
                        r_core_st[cidx(r_tcl, r_tco)] <= PS_ON;
                        if (r_cmd.op == OP_POLL) begin
                            r_tcl <= scan_cl;
                            r_tco <= scan_co;
                        end
                    end
                end
                S_SCAN: begin
                    if (!(hit && cur_core == PS_OFF && r_tco < core_cnt(i_cfg, r_tcl))) begin
                        r_tcl <= scan_cl;
                        r_tco <= scan_co;
                    end
                end
                default: begin
                    r_err <= r_err;
                end
            endcase
        end
    end

    hpsc_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

endmodule

>>> hdl/hierarchical_power_state_coordinator_top.sv
// Power state coordinator for a CPU complex: cores, clusters and complex.
//
// Requests enter through a queue-style port: an item is taken when push is
// high and full is low. Results leave the same way: the oldest result sits
// on o_res while empty is low and is taken when pop is high.
// Each request yields one to many results; the final one carries last.
// The intake decodes a request in the cycle it is taken and parks it in a
// two-entry command queue, so it keeps accepting while the sequencer works.
// The sequencer takes a command only while idle and then steps through one
// state per result; a poll also walks the core slots of the counted clusters
// and wakes each counted core that is off and has its interrupt pending.
// A request passes the command queue, the sequencer state and the result
// queue before its first result shows on o_res.
// A full result queue stalls the sequencer only; results are never dropped.
// Register writes (APB, pready always high) go to the core and cluster
// counts; they are meant for idle periods only.
// Synchronous reset leaves core 0 of cluster 0, cluster 0 and the complex
// on, everything else off, both queues empty and the counts at their
// defaults of one cluster and four cores per cluster.
module hierarchical_power_state_coordinator_top
    import hpsc_pkg::*;
#(
    parameter int CORES_PER_CLUSTER = CPC_DEFAULT,
    parameter int CLUSTER_COUNT     = CLUSTERS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  t_req        i_req,
    output logic        empty,
    input  logic        pop,
    output t_res        o_res
);
    logic [1:0] r_clusters;
    logic [2:0] r_cores0, r_cores1;
    t_cfg       cfg;
    t_cmd       cmd;
    logic       cmd_empty, cmd_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clusters <= 2'd1;
            r_cores0   <= 3'd4;
            r_cores1   <= 3'd4;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CLUSTERS: r_clusters <= pwdata[1:0];
                REG_CORES0:   r_cores0   <= pwdata[2:0];
                REG_CORES1:   r_cores1   <= pwdata[2:0];
                default:      r_clusters <= r_clusters;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLUSTERS: prdata = {30'd0, r_clusters};
            REG_CORES0:   prdata = {29'd0, r_cores0};
            REG_CORES1:   prdata = {29'd0, r_cores1};
            default:      prdata = '0;
        endcase
    end

    // counts beyond the build limits saturate
    always_comb begin
        cfg.cl_cnt  = (int'(r_clusters) > CLUSTER_COUNT) ? 2'(CLUSTER_COUNT) : r_clusters;
        cfg.co_cnt0 = (int'(r_cores0) > CORES_PER_CLUSTER) ? 3'(CORES_PER_CLUSTER) : r_cores0;
        cfg.co_cnt1 = (int'(r_cores1) > CORES_PER_CLUSTER) ? 3'(CORES_PER_CLUSTER) : r_cores1;
    end

    hpsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty),
        .i_cmd_pop   (cmd_pop)
    );

    hpsc_back #(
        .CORES_PER_CLUSTER (CORES_PER_CLUSTER),
        .CLUSTER_COUNT     (CLUSTER_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
